// ----- src/tksi_pkg.sv -----
`timescale 1ns / 1ps

package tksi_pkg;

   // field widths fixed by the command interface
   localparam int SCORE_W = 24;
   localparam int TIME_W  = 16;
   localparam int LIVES_W = 4;
   localparam int DIFF_W  = 2;
   localparam int TAG_W   = 16;
   localparam int INDEX_W = 4;
   localparam int COUNT_W = 5;

   // command codes
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_READ   = 1'b1;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic [TIME_W-1:0]  play_time;
      logic [LIVES_W-1:0] lives;
      logic [DIFF_W-1:0]  difficulty;
      logic [TAG_W-1:0]   name_tag;
      logic [TAG_W-1:0]   date_tag;
   } entry_type;

   // what one cell hands to the next one down the list
   typedef struct packed {
      logic      valid;
      logic      take;
      entry_type entry;
   } link_type;

endpackage

// ----- src/tksi_cell.sv -----
`timescale 1ns / 1ps

module tksi_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                ins_en,
   input  tksi_pkg::entry_type new_entry,
   input  tksi_pkg::link_type  prev_link,
   output tksi_pkg::link_type  this_link
);

   logic                valid_ff, valid_in;
   tksi_pkg::entry_type entry_ff, entry_in;
   logic                take;

   // an empty slot or a strictly lower score gives way to the new entry
   assign take = !valid_ff || (new_entry.score > entry_ff.score);

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (ins_en) begin
         if (prev_link.take) begin
            valid_in = prev_link.valid;
            entry_in = prev_link.entry;
         end else if (take) begin
            valid_in = 1'b1;
            entry_in = new_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign this_link.valid = valid_ff;
   assign this_link.take  = take;
   assign this_link.entry = entry_ff;

endmodule

// ----- src/top_k_sorted_insert.sv -----
`timescale 1ns / 1ps

// Top-K sorted list of scored entries, highest score first. A command is
// transferred on a clock edge where start is high and busy is low; busy stays
// low, so one command can be issued every cycle. Each command yields exactly
// one response, shown on the rsp_ ports in the cycle after its transfer with
// rsp_valid high; the receiver cannot stall it and must take it
// in that cycle. An insert (req_cmd 0) lands ahead of the first entry with a
// strictly lower score, so ties go behind older entries; when the list is
// full and the new score beats nothing, it is rejected (rsp_accepted 0). A
// read (req_cmd 1) returns the entry at req_read_index, with all entry fields
// zero when that position holds nothing. The list is a row of LIST_DEPTH
// cells, each comparing its own score with the new one and shifting its
// entry to its lower neighbor in the same cycle. Reset empties the list.
module top_k_sorted_insert #(
   parameter int LIST_DEPTH = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_cmd,
   input  logic [tksi_pkg::SCORE_W-1:0]   req_score,
   input  logic [tksi_pkg::TIME_W-1:0]    req_play_time,
   input  logic [tksi_pkg::LIVES_W-1:0]   req_lives,
   input  logic [tksi_pkg::DIFF_W-1:0]    req_difficulty,
   input  logic [tksi_pkg::TAG_W-1:0]     req_name_tag,
   input  logic [tksi_pkg::TAG_W-1:0]     req_date_tag,
   input  logic [tksi_pkg::INDEX_W-1:0]   req_read_index,
   output logic                           rsp_valid,
   output logic                           rsp_accepted,
   output logic [tksi_pkg::INDEX_W-1:0]   rsp_position,
   output logic [tksi_pkg::COUNT_W-1:0]   rsp_count,
   output logic                           rsp_entry_valid,
   output logic [tksi_pkg::SCORE_W-1:0]   rsp_entry_score,
   output logic [tksi_pkg::TIME_W-1:0]    rsp_entry_time,
   output logic [tksi_pkg::LIVES_W-1:0]   rsp_entry_lives,
   output logic [tksi_pkg::DIFF_W-1:0]    rsp_entry_difficulty,
   output logic [tksi_pkg::TAG_W-1:0]     rsp_entry_name_tag,
   output logic [tksi_pkg::TAG_W-1:0]     rsp_entry_date_tag
);

   localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W = $clog2(LIST_DEPTH + 1);

   // --- command decode ---
   logic                xfer;
   logic                ins_en;
   tksi_pkg::entry_type new_entry;

   assign busy   = 1'b0;   // never busy: no command holds off the next
   assign xfer   = start && !busy;
   assign ins_en = xfer && (req_cmd == tksi_pkg::CMD_INSERT);

   assign new_entry.score      = req_score;
   assign new_entry.play_time  = req_play_time;
   assign new_entry.lives      = req_lives;
   assign new_entry.difficulty = req_difficulty;
   assign new_entry.name_tag   = req_name_tag;
   assign new_entry.date_tag   = req_date_tag;

   // --- cell row ---
   // chain[i] feeds cell i; chain[i+1] is what cell i shows. The head of the
   // row never shifts, so its upstream link is all zeros.
   tksi_pkg::link_type  chain [LIST_DEPTH+1];
   tksi_pkg::entry_type cell_entry [LIST_DEPTH];
   logic [LIST_DEPTH-1:0] take_vec;
   logic [LIST_DEPTH-1:0] valid_vec;

   assign chain[0] = '0;

   for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
      tksi_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ins_en    (ins_en),
         .new_entry (new_entry),
         .prev_link (chain[g]),
         .this_link (chain[g+1])
      );
      assign cell_entry[g] = chain[g+1].entry;
      assign take_vec[g]   = chain[g+1].take;
      assign valid_vec[g]  = chain[g+1].valid;
   end

   // --- landing position: first cell that gives way ---
   // take is monotone down the row, so the first set bit is the insert point.
   logic             ins_hit;
   logic [IDX_W-1:0] ins_pos;

   assign ins_hit = |take_vec;

   always_comb begin
      ins_pos = '0;
      for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
         if (take_vec[i]) begin
            ins_pos = IDX_W'(i);
         end
      end
   end

   // --- entry count ---
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (ins_en && ins_hit && (count_ff < CNT_W'(LIST_DEPTH))) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // --- read port ---
   logic                rd_hit;
   tksi_pkg::entry_type rd_entry;

   // read_index below count implies it is below LIST_DEPTH
   assign rd_hit = (tksi_pkg::COUNT_W'(req_read_index) < tksi_pkg::COUNT_W'(count_ff));

   always_comb begin
      rd_entry = '0;
      if (rd_hit) begin
         rd_entry = cell_entry[req_read_index[IDX_W-1:0]];
      end
   end

   // --- response register ---
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             accepted_ff, accepted_in;
   logic [tksi_pkg::INDEX_W-1:0]     position_ff, position_in;
   logic [tksi_pkg::COUNT_W-1:0]     count_out_ff, count_out_in;
   logic                             entry_valid_ff, entry_valid_in;
   tksi_pkg::entry_type              entry_out_ff, entry_out_in;

   assign rsp_valid_in = xfer;

   always_comb begin
      accepted_in    = 1'b0;
      position_in    = '0;
      count_out_in   = tksi_pkg::COUNT_W'(count_in);
      entry_valid_in = 1'b0;
      entry_out_in   = '0;
      if (req_cmd == tksi_pkg::CMD_INSERT) begin
         if (ins_hit) begin
            accepted_in = 1'b1;
            position_in = tksi_pkg::INDEX_W'(ins_pos);
         end
      end else begin
         entry_valid_in = rd_hit;
         entry_out_in   = rd_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      accepted_ff    <= accepted_in;
      position_ff    <= position_in;
      count_out_ff   <= count_out_in;
      entry_valid_ff <= entry_valid_in;
      entry_out_ff   <= entry_out_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_accepted         = accepted_ff;
   assign rsp_position         = position_ff;
   assign rsp_count            = count_out_ff;
   assign rsp_entry_valid      = entry_valid_ff;
   assign rsp_entry_score      = entry_out_ff.score;
   assign rsp_entry_time       = entry_out_ff.play_time;
   assign rsp_entry_lives      = entry_out_ff.lives;
   assign rsp_entry_difficulty = entry_out_ff.difficulty;
   assign rsp_entry_name_tag   = entry_out_ff.name_tag;
   assign rsp_entry_date_tag   = entry_out_ff.date_tag;

`ifndef SYNTH
   // one response strobe per transferred command, in the following cycle;
   // a start seen while reset is held launches nothing
   a_rsp_follows_xfer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid == $past(xfer && !reset))
      else $error("response strobe does not match command transfer");

   // counter agrees with the number of occupied cells
   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("entry count out of step with cell valid bits");

   // occupied cells form a prefix of the row
   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      ((valid_vec + LIST_DEPTH'(1)) & valid_vec) == '0)
      else $error("hole in the list of valid cells");

   // an accepted insert lands inside the new count
   a_position_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_accepted) |->
         (tksi_pkg::COUNT_W'(rsp_position) < rsp_count))
      else $error("insert position beyond list count");
`endif

endmodule
